// ===== rtl/akrf_pkg.sv =====
`timescale 1ns / 1ps

package akrf_pkg;

	localparam int SAMPLE_W = 32;
	localparam int VAR_W    = 48;
	localparam int DEN_W    = VAR_W + 1;
	localparam int GAIN_W   = 17;
	localparam int FRAC_W   = 16;
	localparam int SUM_W    = 64;
	localparam int SQ_W     = 56;
	localparam int MS_W     = 54;
	localparam int CFG_W    = 32;
	localparam int REG_IDX_W = 1;

	localparam logic [VAR_W-1:0]  VAR_MAX   = {VAR_W{1'b1}};
	localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;
	localparam logic [VAR_W-1:0]  P_RESET   = 48'd1677722;
	localparam logic [VAR_W-1:0]  Q_RESET   = 48'd167772;
	localparam logic [CFG_W-1:0]  R_RESET   = 32'd167772;
	localparam logic [GAIN_W-1:0] SNAP_RESET = 17'd32768;

	localparam logic [REG_IDX_W-1:0] REG_MEAS_NOISE = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_SNAP_GAIN  = 1'b1;

	typedef struct packed {
		logic take;
		logic inn;
		logic sqo;
		logic sqn;
		logic acc;
		logic ms_go;
		logic mul1;
		logic mul2;
		logic fin;
	} akrf_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} akrf_sts_t;

endpackage

// ===== rtl/akrf_div.sv =====
`timescale 1ns / 1ps

module akrf_div #(
	parameter int QW   = 17,
	parameter int RW   = 49,
	parameter int STEP = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RW-1:0] rem_init,
	input  logic [QW-1:0] low_bits,
	input  logic [RW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quot
);

	localparam int NCYC = QW / STEP;
	localparam int CW   = $clog2(NCYC + 1);

	logic [RW-1:0] rem_q;
	logic [RW-1:0] div_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [RW-1:0] r_nx;
	logic [QW-1:0] q_nx;
	logic [RW:0]   t;

	// restoring division, STEP quotient bits per cycle; rem_init must be below divisor
	always_comb begin
		r_nx = rem_q;
		q_nx = quo_q;
		t    = '0;
		for (int i = 0; i < STEP; i++) begin
			t    = {r_nx, q_nx[QW-1]};
			q_nx = {q_nx[QW-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t       = t - {1'b0, div_q};
				q_nx[0] = 1'b1;
			end
			r_nx = t[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(NCYC);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= low_bits;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= r_nx;
			quo_q <= q_nx;
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== rtl/akrf_datapath.sv =====
`timescale 1ns / 1ps

module akrf_datapath #(
	parameter int WINDOW_LEN = 50
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  akrf_pkg::akrf_cmd_t                  cmd,
	output akrf_pkg::akrf_sts_t                  sts,
	input  logic [akrf_pkg::SAMPLE_W-1:0]        sample,
	output logic [akrf_pkg::SAMPLE_W-1:0]        out_rate,
	output logic                                 out_snap,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic                                 cfg_we,
	input  logic [akrf_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [akrf_pkg::CFG_W-1:0]           cfg_data
);

	localparam int SLOT_W = $clog2(WINDOW_LEN);
	localparam int SW     = akrf_pkg::SAMPLE_W;
	localparam int VW     = akrf_pkg::VAR_W;
	localparam int GW     = akrf_pkg::GAIN_W;

	// sum stays below 2^63; ceil(2^(63+L)/len) gives an exact floor for every such sum
	localparam int MS_L  = $clog2(WINDOW_LEN);
	localparam int MS_SH = 63 + MS_L;
	localparam logic [127:0] MS_RECIP_W =
		((128'd1 << MS_SH) + 128'(WINDOW_LEN - 1)) / 128'(WINDOW_LEN);
	localparam logic [63:0]  MS_RECIP = 64'(MS_RECIP_W);

	// config
	logic [akrf_pkg::CFG_W-1:0] r_q;
	logic [GW-1:0]              snap_q;

	// filter state
	logic signed [SW-1:0]       est_q;
	logic [VW-1:0]              p_q;
	logic [VW-1:0]              q_q;
	logic [akrf_pkg::SUM_W-1:0] sum_q;
	logic [SLOT_W-1:0]          slot_q;
	logic                       wrapped_q;
	logic [SW-1:0]              win_mem [WINDOW_LEN];

	// per-item working registers
	logic [SW-1:0]              sample_q;
	logic [SW-1:0]              inn_q;
	logic                       inn_neg_q;
	logic [SW-1:0]              inn_mag_q;
	logic [VW-1:0]              pmid_q;
	logic [SW-1:0]              rd_q;
	logic [akrf_pkg::SQ_W-1:0]  sq_q;
	logic                       kzero_q;
	logic [GW-1:0]              k_q;
	logic [GW+SW-1:0]           prodm_q;
	logic [GW-1:0]              k2_q;
	logic [VW-1:0]              pnew_q;
	logic [SW-1:0]              rnd_q;
	logic [GW+akrf_pkg::MS_W-1:0] qprod_q;

	// window mean: sum times the reciprocal, one 32x32 partial product a cycle
	logic [1:0]                 ms_cnt_q;
	logic                       ms_busy_q;
	logic                       ms_done_q;
	logic [127:0]               ms_acc_q;

	logic [SW-1:0]              out_rate_q;
	logic                       out_snap_q;
	logic                       out_valid_q;

	// combinational
	logic signed [SW:0]         diff;
	logic [SW-1:0]              inn_sat;
	logic [VW:0]                pq_sum;
	logic [akrf_pkg::DEN_W-1:0] den;
	logic [SW-1:0]              old_val;
	logic [SW-1:0]              old_mag;
	logic [SW-1:0]              sq_in;
	logic [2*SW-1:0]            sq_full;
	logic [GW-1:0]              k_quot;
	logic                       k_done;
	logic [GW-1:0]              k_val;
	logic [2*GW-1:0]            kk;
	logic [GW+VW-1:0]           pfull;
	logic [31:0]                ms_a;
	logic [31:0]                ms_b;
	logic [63:0]                ms_pp;
	logic [127:0]               ms_add;
	logic [akrf_pkg::MS_W-1:0]  ms_quot;
	logic                       ms_done;
	logic [VW-1:0]              rnd_sum;
	logic [SW+1:0]              delta;
	logic [SW+1:0]              est_sum;
	logic [SW-1:0]              est_sat;
	logic [VW-1:0]              q_next;
	logic                       snap;
	logic [SW-1:0]              est_next;

	assign diff    = {sample_q[SW-1], sample_q} - {est_q[SW-1], est_q};
	assign inn_sat = (diff[SW] != diff[SW-1])
		? (diff[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
		: diff[SW-1:0];

	assign pq_sum = {1'b0, p_q} + {1'b0, q_q};
	assign den    = {1'b0, pmid_q} + akrf_pkg::DEN_W'(r_q);

	// an entry not yet written since reset reads as zero
	assign old_val = wrapped_q ? rd_q : '0;
	assign old_mag = old_val[SW-1] ? (~old_val + SW'(1)) : old_val;
	assign sq_in   = cmd.sqo ? old_mag : inn_mag_q;
	assign sq_full = sq_in * sq_in;

	assign k_val = kzero_q ? '0 : k_quot;
	assign kk    = k_val * k_val;
	assign pfull = (akrf_pkg::GAIN_ONE - k_val) * pmid_q;

	assign ms_a    = ms_cnt_q[0] ? {1'b0, sum_q[62:32]} : sum_q[31:0];
	assign ms_b    = ms_cnt_q[1] ? MS_RECIP[63:32] : MS_RECIP[31:0];
	assign ms_pp   = ms_a * ms_b;
	assign ms_add  = (ms_cnt_q == 2'd3) ? {ms_pp, 64'd0}
		: ((ms_cnt_q == 2'd0) ? {64'd0, ms_pp} : {32'd0, ms_pp, 32'd0});
	assign ms_quot = ms_acc_q[MS_SH +: akrf_pkg::MS_W];
	assign ms_done = ms_done_q;

	assign rnd_sum = VW'(prodm_q) + VW'(32768);

	assign delta   = inn_neg_q ? (~{2'b00, rnd_q} + (SW+2)'(1)) : {2'b00, rnd_q};
	assign est_sum = {{2{est_q[SW-1]}}, est_q} + delta;
	assign est_sat = (est_sum[SW+1:SW-1] == 3'b000 || est_sum[SW+1:SW-1] == 3'b111)
		? est_sum[SW-1:0]
		: (est_sum[SW+1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

	assign q_next   = (qprod_q[GW+akrf_pkg::MS_W-1:64] != '0) ? akrf_pkg::VAR_MAX
		: qprod_q[63:16];
	assign snap     = k_q > snap_q;
	assign est_next = snap ? sample_q : est_sat;

	akrf_div #(
		.QW  (GW),
		.RW  (akrf_pkg::DEN_W),
		.STEP(1)
	) u_kdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.sqo),
		.rem_init({2'b00, pmid_q[VW-1:1]}),
		.low_bits({pmid_q[0], {akrf_pkg::FRAC_W{1'b0}}}),
		.divisor (den),
		.done    (k_done),
		.quot    (k_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q         <= akrf_pkg::R_RESET;
			snap_q      <= akrf_pkg::SNAP_RESET;
			est_q       <= '0;
			p_q         <= akrf_pkg::P_RESET;
			q_q         <= akrf_pkg::Q_RESET;
			sum_q       <= '0;
			slot_q      <= '0;
			wrapped_q   <= 1'b0;
			ms_cnt_q    <= '0;
			ms_busy_q   <= 1'b0;
			ms_done_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					akrf_pkg::REG_MEAS_NOISE: r_q <= cfg_data;
					akrf_pkg::REG_SNAP_GAIN:  snap_q <= cfg_data[GW-1:0];
					default: ;
				endcase
			end
			if (cmd.sqn)
				sum_q <= sum_q - akrf_pkg::SUM_W'(sq_q);
			if (cmd.acc) begin
				sum_q <= sum_q + akrf_pkg::SUM_W'(sq_q);
				if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
					slot_q    <= '0;
					wrapped_q <= 1'b1;
				end else begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
			if (cmd.ms_go) begin
				ms_cnt_q  <= '0;
				ms_busy_q <= 1'b1;
				ms_done_q <= 1'b0;
			end else if (ms_busy_q) begin
				ms_cnt_q <= ms_cnt_q + 2'd1;
				if (ms_cnt_q == 2'd3) begin
					ms_busy_q <= 1'b0;
					ms_done_q <= 1'b1;
				end
			end
			if (cmd.fin) begin
				est_q       <= est_next;
				p_q         <= pnew_q;
				q_q         <= q_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			sample_q <= sample;
		if (cmd.inn) begin
			inn_q  <= inn_sat;
			pmid_q <= pq_sum[VW] ? akrf_pkg::VAR_MAX : pq_sum[VW-1:0];
			rd_q   <= win_mem[slot_q];
		end
		if (cmd.sqo) begin
			win_mem[slot_q] <= inn_q;
			inn_neg_q <= inn_q[SW-1];
			inn_mag_q <= inn_q[SW-1] ? (~inn_q + SW'(1)) : inn_q;
			kzero_q   <= (den == '0);
		end
		if (cmd.sqo || cmd.sqn)
			sq_q <= sq_full[2*SW-1:8];
		if (cmd.ms_go)
			ms_acc_q <= '0;
		else if (ms_busy_q)
			ms_acc_q <= ms_acc_q + ms_add;
		if (cmd.mul1) begin
			k_q     <= k_val;
			prodm_q <= k_val * inn_mag_q;
			k2_q    <= kk[2*GW-2:akrf_pkg::FRAC_W];
			pnew_q  <= pfull[VW+akrf_pkg::FRAC_W-1:akrf_pkg::FRAC_W];
		end
		if (cmd.mul2) begin
			rnd_q   <= rnd_sum[VW-1:akrf_pkg::FRAC_W];
			qprod_q <= k2_q * ms_quot;
		end
		if (cmd.fin) begin
			out_rate_q <= est_next;
			out_snap_q <= snap;
		end
	end

	assign sts.div_done = k_done && ms_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_rate  = out_rate_q;
	assign out_snap  = out_snap_q;
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/akrf_ctrl.sv =====
`timescale 1ns / 1ps

module akrf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  akrf_pkg::akrf_sts_t sts,
	output akrf_pkg::akrf_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INN,
		ST_SQO,
		ST_SQN,
		ST_ACC,
		ST_MS,
		ST_WAIT,
		ST_MUL1,
		ST_MUL2,
		ST_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_INN;
				ST_INN:  state_q <= ST_SQO;
				ST_SQO:  state_q <= ST_SQN;
				ST_SQN:  state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_MS;
				ST_MS:   state_q <= ST_WAIT;
				ST_WAIT: if (sts.div_done) state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN:  if (sts.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.take  = in_valid;
			ST_INN:  cmd.inn   = 1'b1;
			ST_SQO:  cmd.sqo   = 1'b1;
			ST_SQN:  cmd.sqn   = 1'b1;
			ST_ACC:  cmd.acc   = 1'b1;
			ST_MS:   cmd.ms_go = 1'b1;
			ST_WAIT: ;
			ST_MUL1: cmd.mul1  = 1'b1;
			ST_MUL2: cmd.mul2  = 1'b1;
			ST_FIN:  cmd.fin   = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== rtl/adaptive_kalman_rate_filter.sv =====
`timescale 1ns / 1ps
// An item is accepted only while idle, after the last one is done; the serial gain divide is the longest step.
// The window mean (reciprocal multiply) finishes inside the gain divide.
// A result waiting on the output holds the next item at its final step only.
// Reset (arst_n low) restores config, estimate, variances and the window at once.

module adaptive_kalman_rate_filter #(
	parameter int WINDOW_LEN = 50
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [31:0]                      s_axis_tdata,  // [31:0] rate_sample
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [31:0]                      m_axis_tdata,  // [31:0] filtered_rate
	output logic                             m_axis_tuser,  // [0] snapped
	input  logic                             cfg_we,
	input  logic [akrf_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [akrf_pkg::CFG_W-1:0]       cfg_data
);

	akrf_pkg::akrf_cmd_t cmd;
	akrf_pkg::akrf_sts_t sts;

	akrf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	akrf_datapath #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.sample   (s_axis_tdata),
		.out_rate (m_axis_tdata),
		.out_snap (m_axis_tuser),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

endmodule
